// ===== hdl/ecpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ecpa_pkg: shared constants for the affine curve point unit
// Default field width, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ecpa_pkg;

    localparam int FIELD_BITS_DEF = 16;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_MUL   = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    localparam logic [1:0] REG_PRIME = 2'd0;
    localparam logic [1:0] REG_A     = 2'd1;
    localparam logic [1:0] REG_B     = 2'd2;

    localparam logic [63:0] RST_PRIME = 64'd257;
    localparam logic [63:0] RST_A     = 64'd0;
    localparam logic [63:0] RST_B     = 64'd253;

endpackage

// ===== hdl/ecpa_mulmod.sv =====
// ----------------------------------------------------------------------------
// ecpa_mulmod: bit-serial modular multiplier
// Computes x*y mod m, scanning x from its top bit, one bit per cycle.
// ----------------------------------------------------------------------------
module ecpa_mulmod #(
    parameter int FIELD_BITS = ecpa_pkg::FIELD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [FIELD_BITS-1:0] i_x,
    input  logic [FIELD_BITS-1:0] i_y,
    input  logic [FIELD_BITS-1:0] i_m,
    output logic                  o_done,
    output logic [FIELD_BITS-1:0] o_prod
);

    localparam int W  = FIELD_BITS;
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_xs;
    logic [W-1:0]  r_y;

    logic [W:0] dbl;
    logic [W:0] dbl_red;
    logic [W:0] sum;
    logic [W:0] sum_red;

    // Double the accumulator, reduce, then add y when the scanned bit is set.
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_m}) ? dbl - {1'b0, i_m} : dbl;
        sum     = dbl_red + (r_xs[W-1] ? {1'b0, r_y} : {(W+1){1'b0}});
        sum_red = (sum >= {1'b0, i_m}) ? sum - {1'b0, i_m} : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_acc  <= '0;
                r_xs   <= i_x;
                r_y    <= i_y;
            end else if (r_busy) begin
                r_acc <= sum_red[W-1:0];
                r_xs  <= {r_xs[W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hdl/ec_point_add_mul_prime_field.sv =====
// ----------------------------------------------------------------------------
// ec_point_add_mul_prime_field: affine point add, scalar multiply, curve check
// Sequenced point arithmetic on y^2 = x^3 + a*x + b over GF(p).
// ----------------------------------------------------------------------------
// This block takes one command at a time and holds o_in_stall high until it
// has finished. All products run on one bit-serial modular multiplier;
// additions and subtractions mod p are combinational.
// Operand reduction costs six products. A point add costs at most
// 2*FIELD_BITS + 5 products, since the slope inverse is d^(p-2) by
// square-and-multiply. A scalar multiply by n runs n - 1 point adds, so it
// scales linearly in n. The curve check is four products. A finished result
// waits in an output register, and the next command is taken while that
// result is still waiting.
module ec_point_add_mul_prime_field #(
    parameter int FIELD_BITS = ecpa_pkg::FIELD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [FIELD_BITS-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_cmd,
    input  logic [FIELD_BITS-1:0] i_first_x,
    input  logic [FIELD_BITS-1:0] i_first_y,
    input  logic [FIELD_BITS-1:0] i_second_x,
    input  logic [FIELD_BITS-1:0] i_second_y,
    input  logic [FIELD_BITS-1:0] i_scalar,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FIELD_BITS-1:0] o_result_x,
    output logic [FIELD_BITS-1:0] o_result_y,
    output logic                  o_on_curve,
    output logic                  o_degenerate,
    output logic                  o_bad_scalar
);

    localparam int W = FIELD_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_MWAIT, S_RA, S_RB, S_RPX, S_RPY, S_RQX, S_RQY, S_DISP,
        S_MLOOP, S_ADD0, S_D1, S_D2, S_P0, S_PL, S_PA, S_PB, S_PC,
        S_L0, S_L1, S_L2, S_L3, S_L4, S_C1, S_C2, S_C3, S_C4, S_DONE
    } t_state;

    // Configuration registers.
    logic [W-1:0] r_cfg_p;
    logic [W-1:0] r_cfg_a;
    logic [W-1:0] r_cfg_b;

    t_state       r_state;
    t_state       r_ret;
    logic [1:0]   r_cmd;
    logic [W-1:0] r_m;
    logic [W-1:0] r_a;
    logic [W-1:0] r_b;
    logic [W-1:0] r_px;
    logic [W-1:0] r_py;
    logic [W-1:0] r_qx;
    logic [W-1:0] r_qy;
    logic [W-1:0] r_n;
    logic [W-1:0] r_ux;
    logic [W-1:0] r_uy;
    logic [W-1:0] r_vx;
    logic [W-1:0] r_vy;
    logic [W-1:0] r_num;
    logic [W-1:0] r_den;
    logic [W-1:0] r_pacc;
    logic [W-1:0] r_base;
    logic [W-1:0] r_exp;
    logic [W-1:0] r_lam;
    logic [W-1:0] r_x3;
    logic [W-1:0] r_rx;
    logic [W-1:0] r_ry;
    logic         r_oc;
    logic         r_dg;
    logic         r_bs;

    logic         r_mstart;
    logic [W-1:0] r_mx;
    logic [W-1:0] r_my;
    logic         mul_done;
    logic [W-1:0] mul_prod;

    logic         r_out_valid;
    logic [W-1:0] r_out_x;
    logic [W-1:0] r_out_y;
    logic         r_out_oc;
    logic         r_out_dg;
    logic         r_out_bs;

    logic         in_xfer;
    logic [W-1:0] cfg_m;
    logic [W-1:0] three;
    logic         same_pt;

    function automatic logic [W-1:0] add_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sub_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
        logic [W:0] s;
        if (x >= y) begin
            s = {1'b0, x} - {1'b0, y};
        end else begin
            s = {1'b0, x} + {1'b0, m} - {1'b0, y};
        end
        return s[W-1:0];
    endfunction

    // A modulus below three is taken as three.
    assign cfg_m   = (r_cfg_p < W'(3)) ? W'(3) : r_cfg_p;
    assign three   = (r_m == W'(3)) ? '0 : W'(3);
    assign same_pt = (r_ux == r_vx) && (r_uy == r_vy);
    assign in_xfer = i_in_valid && !o_in_stall;

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_p <= W'(ecpa_pkg::RST_PRIME);
            r_cfg_a <= W'(ecpa_pkg::RST_A);
            r_cfg_b <= W'(ecpa_pkg::RST_B);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ecpa_pkg::REG_PRIME: r_cfg_p <= i_cfg_data;
                ecpa_pkg::REG_A:     r_cfg_a <= i_cfg_data;
                ecpa_pkg::REG_B:     r_cfg_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ecpa_mulmod #(
        .FIELD_BITS(W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_x     (r_mx),
        .i_y     (r_my),
        .i_m     (r_m),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Sequencer. A state that needs a product loads the multiplier operands,
    // names its follow-up state in r_ret and parks in S_MWAIT until the
    // product is ready. Reducing a value mod p is a product by one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_mstart    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd   <= i_cmd;
                        r_m     <= cfg_m;
                        r_px    <= i_first_x;
                        r_py    <= i_first_y;
                        r_qx    <= i_second_x;
                        r_qy    <= i_second_y;
                        r_n     <= i_scalar;
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_oc    <= 1'b0;
                        r_dg    <= 1'b0;
                        r_bs    <= 1'b0;
                        r_state <= S_RA;
                    end
                end
                S_MWAIT: begin
                    if (mul_done) begin
                        r_state <= r_ret;
                    end
                end
                S_RA: begin
                    r_mx <= r_cfg_a; r_my <= W'(1); r_mstart <= 1'b1;
                    r_ret <= S_RB; r_state <= S_MWAIT;
                end
                S_RB: begin
                    r_a <= mul_prod;
                    r_mx <= r_cfg_b; r_my <= W'(1); r_mstart <= 1'b1;
                    r_ret <= S_RPX; r_state <= S_MWAIT;
                end
                S_RPX: begin
                    r_b <= mul_prod;
                    r_mx <= r_px; r_my <= W'(1); r_mstart <= 1'b1;
                    r_ret <= S_RPY; r_state <= S_MWAIT;
                end
                S_RPY: begin
                    r_px <= mul_prod;
                    r_mx <= r_py; r_my <= W'(1); r_mstart <= 1'b1;
                    r_ret <= S_RQX; r_state <= S_MWAIT;
                end
                S_RQX: begin
                    r_py <= mul_prod;
                    r_mx <= r_qx; r_my <= W'(1); r_mstart <= 1'b1;
                    r_ret <= S_RQY; r_state <= S_MWAIT;
                end
                S_RQY: begin
                    r_qx <= mul_prod;
                    r_mx <= r_qy; r_my <= W'(1); r_mstart <= 1'b1;
                    r_ret <= S_DISP; r_state <= S_MWAIT;
                end
                S_DISP: begin
                    r_qy <= mul_prod;
                    case (r_cmd)
                        ecpa_pkg::CMD_ADD: begin
                            r_ux <= r_px; r_uy <= r_py;
                            r_vx <= r_qx; r_vy <= mul_prod;
                            r_state <= S_ADD0;
                        end
                        ecpa_pkg::CMD_MUL: begin
                            if (r_n == '0) begin
                                r_bs    <= 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_rx    <= r_px;
                                r_ry    <= r_py;
                                r_n     <= r_n - 1'b1;
                                r_state <= S_MLOOP;
                            end
                        end
                        ecpa_pkg::CMD_CHECK: begin
                            r_mx <= r_py; r_my <= r_py; r_mstart <= 1'b1;
                            r_ret <= S_C1; r_state <= S_MWAIT;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MLOOP: begin
                    if (r_n == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ux <= r_rx; r_uy <= r_ry;
                        r_vx <= r_px; r_vy <= r_py;
                        r_state <= S_ADD0;
                    end
                end
                // Point add of (ux, uy) and (vx, vy).
                S_ADD0: begin
                    if (same_pt) begin
                        r_mx <= r_ux; r_my <= r_ux; r_mstart <= 1'b1;
                        r_ret <= S_D1; r_state <= S_MWAIT;
                    end else begin
                        r_num   <= sub_m(r_vy, r_uy, r_m);
                        r_den   <= sub_m(r_vx, r_ux, r_m);
                        r_state <= S_P0;
                    end
                end
                S_D1: begin
                    r_mx <= three; r_my <= mul_prod; r_mstart <= 1'b1;
                    r_ret <= S_D2; r_state <= S_MWAIT;
                end
                S_D2: begin
                    r_num   <= add_m(mul_prod, r_a, r_m);
                    r_den   <= add_m(r_uy, r_uy, r_m);
                    r_state <= S_P0;
                end
                S_P0: begin
                    r_pacc  <= W'(1);
                    r_base  <= r_den;
                    r_exp   <= r_m - W'(2);
                    r_state <= S_PL;
                end
                S_PL: begin
                    if (r_exp == '0) begin
                        r_state <= S_L0;
                    end else if (r_exp[0]) begin
                        r_mx <= r_pacc; r_my <= r_base; r_mstart <= 1'b1;
                        r_ret <= S_PA; r_state <= S_MWAIT;
                    end else begin
                        r_state <= S_PB;
                    end
                end
                S_PA: begin
                    r_pacc  <= mul_prod;
                    r_state <= S_PB;
                end
                S_PB: begin
                    r_mx <= r_base; r_my <= r_base; r_mstart <= 1'b1;
                    r_ret <= S_PC; r_state <= S_MWAIT;
                end
                S_PC: begin
                    r_base  <= mul_prod;
                    r_exp   <= r_exp >> 1;
                    r_state <= S_PL;
                end
                S_L0: begin
                    r_mx <= r_num; r_my <= r_pacc; r_mstart <= 1'b1;
                    r_ret <= S_L1; r_state <= S_MWAIT;
                end
                S_L1: begin
                    r_lam <= mul_prod;
                    r_mx <= mul_prod; r_my <= mul_prod; r_mstart <= 1'b1;
                    r_ret <= S_L2; r_state <= S_MWAIT;
                end
                S_L2: begin
                    r_x3    <= sub_m(sub_m(mul_prod, r_ux, r_m), r_vx, r_m);
                    r_state <= S_L3;
                end
                S_L3: begin
                    r_mx <= r_lam; r_my <= sub_m(r_ux, r_x3, r_m); r_mstart <= 1'b1;
                    r_ret <= S_L4; r_state <= S_MWAIT;
                end
                S_L4: begin
                    r_rx <= r_x3;
                    r_ry <= sub_m(mul_prod, r_uy, r_m);
                    if (r_den == '0) begin
                        r_dg <= 1'b1;
                    end
                    if (r_cmd == ecpa_pkg::CMD_ADD) begin
                        r_state <= S_DONE;
                    end else begin
                        r_n     <= r_n - 1'b1;
                        r_state <= S_MLOOP;
                    end
                end
                // Curve check: y^2 against x^3 + a*x + b.
                S_C1: begin
                    r_num <= mul_prod;
                    r_mx <= r_px; r_my <= r_px; r_mstart <= 1'b1;
                    r_ret <= S_C2; r_state <= S_MWAIT;
                end
                S_C2: begin
                    r_mx <= mul_prod; r_my <= r_px; r_mstart <= 1'b1;
                    r_ret <= S_C3; r_state <= S_MWAIT;
                end
                S_C3: begin
                    r_den <= mul_prod;
                    r_mx <= r_a; r_my <= r_px; r_mstart <= 1'b1;
                    r_ret <= S_C4; r_state <= S_MWAIT;
                end
                S_C4: begin
                    r_oc    <= (r_num == add_m(add_m(r_den, mul_prod, r_m), r_b, r_m));
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hand over to the output register once it is free.
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_rx;
                        r_out_y     <= r_ry;
                        r_out_oc    <= r_oc;
                        r_out_dg    <= r_dg;
                        r_out_bs    <= r_bs;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_result_x   = r_out_x;
    assign o_result_y   = r_out_y;
    assign o_on_curve   = r_out_oc;
    assign o_degenerate = r_out_dg;
    assign o_bad_scalar = r_out_bs;

    // An accepted command always keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state != S_IDLE))
        else $error("block idle right after accepting a command");

    // A zero scalar gives the origin as its result.
    a_bad_scalar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bs) |-> (r_out_x == '0 && r_out_y == '0 && !r_out_dg))
        else $error("bad scalar result is not zero");

    // The curve check raises no arithmetic flags and returns no point.
    a_check_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_oc) |-> (!r_out_dg && !r_out_bs && r_out_x == '0))
        else $error("curve check result carries stray fields");

endmodule

// ===== bench/ec_point_add_mul_prime_field_tb.sv =====
// ----------------------------------------------------------------------------
// ec_point_add_mul_prime_field_tb: self-checking bench for the curve point unit
// A queue-fed driver offers add, multiply and curve-check commands under
// several field settings and idle patterns. A monitor compares every result
// transfer with the prediction made when the command was accepted.
// ----------------------------------------------------------------------------
module ec_point_add_mul_prime_field_tb;

    localparam int FB = ecpa_pkg::FIELD_BITS_DEF;
    localparam int HOLD_CYCLES = 5000;
    localparam int DRAIN_CYCLES = 2000;

    // Command code and register index that the block leaves unused.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef logic [FB-1:0] t_word;

    typedef struct {
        logic [1:0] cmd;
        t_word      fx;
        t_word      fy;
        t_word      sx;
        t_word      sy;
        t_word      sc;
    } t_point_cmd;

    typedef struct {
        t_word rx;
        t_word ry;
        logic  oc;
        logic  dg;
        logic  bs;
    } t_point_res;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    t_word      i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_cmd = '0;
    t_word      i_first_x = '0;
    t_word      i_first_y = '0;
    t_word      i_second_x = '0;
    t_word      i_second_y = '0;
    t_word      i_scalar = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_word      o_result_x;
    t_word      o_result_y;
    logic       o_on_curve;
    logic       o_degenerate;
    logic       o_bad_scalar;

    ec_point_add_mul_prime_field #(.FIELD_BITS(FB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_cmd(i_cmd), .i_first_x(i_first_x), .i_first_y(i_first_y),
        .i_second_x(i_second_x), .i_second_y(i_second_y), .i_scalar(i_scalar),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_result_x(o_result_x), .o_result_y(o_result_y),
        .o_on_curve(o_on_curve), .o_degenerate(o_degenerate),
        .o_bad_scalar(o_bad_scalar)
    );

    always #4 i_clk = ~i_clk;

    // Bench copy of the field registers, updated with every register write.
    longint unsigned fld_prime = 257;
    longint unsigned fld_a = 0;
    longint unsigned fld_b = 253;

    t_point_cmd pending_cmds[$];
    t_point_res expected_pts[$];
    t_point_cmd cur_cmd;

    int idle_in_pct = 0;
    int idle_out_pct = 0;
    int mismatches = 0;
    bit pressure_on = 1'b0;
    int hold_count = 0;

    // ---- Field arithmetic, operands always below m --------------------------
    function automatic longint unsigned f_add(longint unsigned x, longint unsigned y,
                                              longint unsigned m);
        return (x >= m - y) ? x - (m - y) : x + y;
    endfunction

    function automatic longint unsigned f_sub(longint unsigned x, longint unsigned y,
                                              longint unsigned m);
        return (x >= y) ? x - y : x + (m - y);
    endfunction

    function automatic longint unsigned f_mul(longint unsigned x, longint unsigned y,
                                              longint unsigned m);
        return (x * y) % m;
    endfunction

    function automatic longint unsigned f_pow(longint unsigned base, longint unsigned e,
                                              longint unsigned m);
        longint unsigned acc;
        acc = 64'd1 % m;
        while (e != 0) begin
            if (e[0]) acc = f_mul(acc, base, m);
            base = f_mul(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic longint unsigned field_mod();
        return (fld_prime < 64'd3) ? 64'd3 : fld_prime;
    endfunction

    // Affine add with doubling when the points coincide; returns 1 when the
    // slope denominator vanished, in which case the inverse is taken as zero.
    function automatic bit affine_add(longint unsigned px, longint unsigned py,
                                      longint unsigned qx, longint unsigned qy,
                                      longint unsigned a, longint unsigned m,
                                      output longint unsigned rx,
                                      output longint unsigned ry);
        longint unsigned num, den, lam, x3;
        if (px == qx && py == qy) begin
            num = f_add(f_mul(64'd3 % m, f_mul(px, px, m), m), a, m);
            den = f_add(py, py, m);
        end else begin
            num = f_sub(qy, py, m);
            den = f_sub(qx, px, m);
        end
        lam = f_mul(num, f_pow(den, m - 64'd2, m), m);
        x3 = f_sub(f_sub(f_mul(lam, lam, m), px, m), qx, m);
        rx = x3;
        ry = f_sub(f_mul(lam, f_sub(px, x3, m), m), py, m);
        return den == 0;
    endfunction

    function automatic t_point_res predict_point(t_point_cmd c);
        t_point_res r;
        longint unsigned m, a, b, px, py, qx, qy, rx, ry, tx, ty, lhs, rhs;
        m = field_mod();
        a = fld_a % m;
        b = fld_b % m;
        px = 64'(c.fx) % m;
        py = 64'(c.fy) % m;
        qx = 64'(c.sx) % m;
        qy = 64'(c.sy) % m;
        rx = 0;
        ry = 0;
        r = '{default: '0};
        case (c.cmd)
            ecpa_pkg::CMD_ADD: r.dg = affine_add(px, py, qx, qy, a, m, rx, ry);
            ecpa_pkg::CMD_MUL: begin
                if (c.sc == 0) begin
                    r.bs = 1'b1;
                end else begin
                    rx = px;
                    ry = py;
                    for (int i = 1; i < int'(c.sc); i++) begin
                        if (affine_add(rx, ry, px, py, a, m, tx, ty)) r.dg = 1'b1;
                        rx = tx;
                        ry = ty;
                    end
                end
            end
            ecpa_pkg::CMD_CHECK: begin
                lhs = f_mul(py, py, m);
                rhs = f_add(f_add(f_mul(f_mul(px, px, m), px, m), f_mul(a, px, m), m),
                            b, m);
                r.oc = (lhs == rhs);
            end
            default: ;
        endcase
        r.rx = rx[FB-1:0];
        r.ry = ry[FB-1:0];
        return r;
    endfunction

    // Looks for a point on the current curve; falls back to a random pair.
    function automatic void find_curve_point(output t_word x, output t_word y);
        longint unsigned m, a, b, cx, rhs;
        m = field_mod();
        a = fld_a % m;
        b = fld_b % m;
        x = t_word'($urandom);
        y = t_word'($urandom);
        for (int t = 0; t < 30; t++) begin
            cx = 64'($urandom_range(0, int'(m - 1)));
            rhs = f_add(f_add(f_mul(f_mul(cx, cx, m), cx, m), f_mul(a, cx, m), m), b, m);
            for (longint unsigned cy = 0; cy < m; cy++) begin
                if (f_mul(cy, cy, m) == rhs) begin
                    x = cx[FB-1:0];
                    y = cy[FB-1:0];
                    return;
                end
            end
        end
    endfunction

    function automatic t_word rand_coord();
        longint unsigned m;
        m = field_mod();
        // Mostly residues, sometimes raw words that need reduction.
        if ($urandom_range(0, 3) == 0) return t_word'($urandom);
        return t_word'($urandom_range(0, int'(m - 1)));
    endfunction

    function automatic t_point_cmd make_cmd(logic [1:0] cmd, t_word fx, t_word fy,
                                            t_word sx, t_word sy, t_word sc);
        t_point_cmd c;
        c.cmd = cmd; c.fx = fx; c.fy = fy; c.sx = sx; c.sy = sy; c.sc = sc;
        return c;
    endfunction

    // Random command with mostly meaningful operands; multiply scalars stay
    // small since every step is a full point add.
    function automatic t_point_cmd rand_cmd();
        t_point_cmd c;
        longint unsigned m;
        int pick;
        m = field_mod();
        c = make_cmd(2'($urandom_range(0, 2)), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), t_word'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 10) c.cmd = CMD_UNUSED;
        if (c.cmd != CMD_UNUSED && pick < 70) find_curve_point(c.fx, c.fy);
        if (c.cmd == ecpa_pkg::CMD_ADD) begin
            case ($urandom_range(0, 3))
                0: begin c.sx = c.fx; c.sy = c.fy; end
                1: begin
                    c.sx = c.fx;
                    c.sy = t_word'(f_sub(64'd0, 64'(c.fy) % m, m));
                end
                2: find_curve_point(c.sx, c.sy);
                default: ;
            endcase
        end else if (c.cmd == ecpa_pkg::CMD_MUL) begin
            c.sc = ($urandom_range(0, 19) == 0) ? t_word'($urandom_range(20, 40))
                                                : t_word'($urandom_range(0, 10));
        end
        return c;
    endfunction

    // ---- Driver --------------------------------------------------------------
    always @(posedge i_clk) begin
        bit nxt_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_pts.push_back(predict_point(cur_cmd));
                nxt_valid = 1'b0;
            end
            // A new command is only offered once the previous one has transferred,
            // so a held payload never changes.
            if (!nxt_valid && pending_cmds.size() > 0 &&
                $urandom_range(0, 99) >= idle_in_pct) begin
                cur_cmd = pending_cmds.pop_front();
                i_cmd <= cur_cmd.cmd;
                i_first_x <= cur_cmd.fx;
                i_first_y <= cur_cmd.fy;
                i_second_x <= cur_cmd.sx;
                i_second_y <= cur_cmd.sy;
                i_scalar <= cur_cmd.sc;
                nxt_valid = 1'b1;
            end
            i_in_valid <= nxt_valid;
        end
    end

    // Long receiver hold-off, counted in its own process once pressure starts.
    always @(posedge i_clk) begin
        if (pressure_on && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
    end

    // ---- Monitor -------------------------------------------------------------
    always @(posedge i_clk) begin
        t_point_res exp_r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_pts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer x=%0d y=%0d",
                                 o_result_x, o_result_y);
                end else begin
                    exp_r = expected_pts.pop_front();
                    if (o_result_x !== exp_r.rx || o_result_y !== exp_r.ry ||
                        o_on_curve !== exp_r.oc || o_degenerate !== exp_r.dg ||
                        o_bad_scalar !== exp_r.bs) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected x=%0d y=%0d oc=%0b dg=%0b ",
                                      "bs=%0b, got x=%0d y=%0d oc=%0b dg=%0b bs=%0b"},
                                     exp_r.rx, exp_r.ry, exp_r.oc, exp_r.dg, exp_r.bs,
                                     o_result_x, o_result_y, o_on_curve, o_degenerate,
                                     o_bad_scalar);
                    end
                end
            end
            i_out_stall <= (pressure_on && hold_count < HOLD_CYCLES) ||
                           ($urandom_range(0, 99) < idle_out_pct);
        end
    end

    // ---- Sequencing ----------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, t_word value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ecpa_pkg::REG_PRIME: fld_prime = 64'(value);
            ecpa_pkg::REG_A:     fld_a = 64'(value);
            ecpa_pkg::REG_B:     fld_b = 64'(value);
            default:   ;
        endcase
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || i_in_valid || expected_pts.size() != 0);
    endtask

    task automatic run_random(int count, int in_pct, int out_pct);
        idle_in_pct = in_pct;
        idle_out_pct = out_pct;
        for (int k = 0; k < count; k++) pending_cmds.push_back(rand_cmd());
        wait_idle();
    endtask

    initial begin
        t_word cx, cy;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands under the reset curve, p = 257.
        find_curve_point(cx, cy);
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_ADD, 16'd5, 16'd11, 16'd100,
                                        16'd200, 16'd0));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_ADD, cx, cy, cx, cy, 16'hFFFF));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_ADD, cx, cy, cx,
                                        t_word'(16'd257 - (cy % 16'd257)), 16'd0));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_ADD, 16'd2, 16'd0, 16'd2, 16'd0,
                                        16'd0));
        // Operands at or above p compare equal only after reduction.
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_ADD, 16'd260, 16'hFFFF, 16'd3,
                                        16'hFFFF % 16'd257, 16'd0));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        16'd0, 16'd0));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_ADD, 16'd0, 16'd0, 16'd0, 16'd0,
                                        16'd0));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_MUL, cx, cy, 16'd0, 16'd0, 16'd0));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_MUL, 16'hFFFF, 16'hFFFF, 16'd0,
                                        16'd0, 16'd1));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_MUL, cx, cy, 16'd0, 16'd0, 16'd2));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_MUL, cx, cy, 16'hFFFF, 16'hFFFF,
                                        16'd7));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_MUL, 16'd2, 16'd0, 16'd0, 16'd0,
                                        16'd4));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_CHECK, cx, cy, 16'd0, 16'd0,
                                        16'hFFFF));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_CHECK, cx, t_word'(cy + 16'd1),
                                        16'd0, 16'd0, 16'd0));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_CHECK, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        16'hFFFF, 16'hFFFF));
        pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_CHECK, 16'd0, 16'd0, 16'd0, 16'd0,
                                        16'd0));
        pending_cmds.push_back(make_cmd(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        16'hFFFF, 16'd5));
        wait_idle();

        run_random(15, 0, 0);

        // Largest 16-bit prime with coefficients that need reduction.
        write_reg(ecpa_pkg::REG_PRIME, 16'd65521);
        write_reg(ecpa_pkg::REG_A, 16'hFFFF);
        write_reg(ecpa_pkg::REG_B, 16'hFFFF);
        run_random(15, 45, 0);

        // Smallest modulus the block accepts, p = 3.
        write_reg(ecpa_pkg::REG_PRIME, 16'd3);
        write_reg(ecpa_pkg::REG_A, 16'd1);
        write_reg(ecpa_pkg::REG_B, 16'd0);
        run_random(12, 0, 45);

        // Modulus below three is taken as three; the unused index writes nothing.
        write_reg(ecpa_pkg::REG_PRIME, 16'd0);
        write_reg(REG_UNUSED, 16'hFFFF);
        run_random(8, 38, 38);

        // Non-prime modulus at the top of the range.
        write_reg(ecpa_pkg::REG_PRIME, 16'hFFFF);
        write_reg(ecpa_pkg::REG_A, 16'd7);
        write_reg(ecpa_pkg::REG_B, 16'd3);
        run_random(10, 38, 38);

        // Small prime with the receiver held off so the input backs up.
        write_reg(ecpa_pkg::REG_PRIME, 16'd97);
        write_reg(ecpa_pkg::REG_A, 16'd2);
        write_reg(ecpa_pkg::REG_B, 16'd5);
        idle_in_pct = 0;
        idle_out_pct = 0;
        pressure_on = 1'b1;
        for (int k = 0; k < 12; k++)
            pending_cmds.push_back(make_cmd(ecpa_pkg::CMD_ADD, rand_coord(), rand_coord(),
                                            rand_coord(), rand_coord(),
                                            t_word'($urandom)));
        wait_idle();
        run_random(20, 45, 45);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_pts.size() == 0)
            $display("ec_point_add_mul_prime_field_tb: clean");
        else
            $display("ec_point_add_mul_prime_field_tb: errors");
        $finish;
    end

    initial begin
        #80000000;
        $display("ec_point_add_mul_prime_field_tb: errors");
        $finish;
    end

endmodule
